// ===== design/line_follower_pid_drive_defines.svh =====
// Assertion macros used by the design file line_follower_pid_drive.sv.
`ifndef LINE_FOLLOWER_PID_DRIVE_DEFINES_SVH
`define LINE_FOLLOWER_PID_DRIVE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFPID_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFPID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lfpid_pkg.sv =====
package lfpid_pkg;

    localparam int ERR_W   = 11;
    localparam int INTEG_W = 24;
    localparam int DER_W   = 12;
    localparam int GAIN_W  = 16;
    localparam int SPEED_W = 8;
    localparam int OPND_W  = 24;
    localparam int PROD_W  = GAIN_W + 1 + OPND_W;
    localparam int ACC_W   = 42;
    localparam int SUM_W   = 43;

    localparam logic [1:0] REG_GAIN_PROP  = 2'd0;
    localparam logic [1:0] REG_GAIN_INTEG = 2'd1;
    localparam logic [1:0] REG_GAIN_DERIV = 2'd2;
    localparam logic [1:0] REG_BASE_SPEED = 2'd3;

    localparam logic [GAIN_W-1:0]  GAIN_PROP_RST  = 16'd4608;
    localparam logic [GAIN_W-1:0]  GAIN_INTEG_RST = 16'd0;
    localparam logic [GAIN_W-1:0]  GAIN_DERIV_RST = 16'd2560;
    localparam logic [SPEED_W-1:0] BASE_SPEED_RST = 8'd140;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 24'sh7F_FFFF;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = 24'sh80_0000;
    localparam logic [SPEED_W-1:0]        SPEED_MAX = 8'd255;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL_P = 8'b0000_0010,
        ST_MUL_I = 8'b0000_0100,
        ST_MUL_D = 8'b0000_1000,
        ST_ACC   = 8'b0001_0000,
        ST_LEFT  = 8'b0010_0000,
        ST_RIGHT = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } lfpid_state_t;

    // Mean sensor weight in Q8 for each non-empty set of active sensors,
    // truncated toward zero.
    function automatic logic signed [ERR_W-1:0] err_of(input logic [4:0] active);
        logic signed [ERR_W-1:0] e;
        case (active)
            5'd1:    e = -11'sd384;
            5'd2:    e = -11'sd192;
            5'd3:    e = -11'sd288;
            5'd5:    e = -11'sd192;
            5'd6:    e = -11'sd96;
            5'd7:    e = -11'sd192;
            5'd8:    e = 11'sd192;
            5'd9:    e = -11'sd96;
            5'd11:   e = -11'sd128;
            5'd12:   e = 11'sd96;
            5'd13:   e = -11'sd64;
            5'd15:   e = -11'sd96;
            5'd16:   e = 11'sd384;
            5'd18:   e = 11'sd96;
            5'd19:   e = -11'sd64;
            5'd20:   e = 11'sd192;
            5'd22:   e = 11'sd64;
            5'd23:   e = -11'sd48;
            5'd24:   e = 11'sd288;
            5'd25:   e = 11'sd64;
            5'd26:   e = 11'sd128;
            5'd28:   e = 11'sd192;
            5'd29:   e = 11'sd48;
            5'd30:   e = 11'sd96;
            default: e = 11'sd0;
        endcase
        return e;
    endfunction

    // Takes the integer part of a Q16 drive level and clamps it to the motor range.
    function automatic logic [SPEED_W-1:0] speed_of(input logic signed [SUM_W-1:0] q16);
        logic [SPEED_W-1:0] s;
        if (q16[SUM_W-1])
        begin
            s = '0;
        end
        else if (|q16[SUM_W-2:24])
        begin
            s = SPEED_MAX;
        end
        else
        begin
            s = q16[23:16];
        end
        return s;
    endfunction

endpackage

// ===== design/line_follower_pid_drive.sv =====
// Five-sensor PID line follower. Each sensor word is taken on sensor_valid
// with sensor_stall low, and one word carrying left_speed and right_speed
// follows on speed_valid. On acceptance the block forms the error, derivative
// and saturated integral. The states ST_MUL_P, ST_MUL_I and ST_MUL_D are then
// passes through the single 17 by 24 bit multiplier for the proportional,
// integral and derivative terms. ST_ACC adds the last product. Two passes
// through the one wide adder form and clamp each motor speed, and ST_EMIT
// hands the word to the output register.
// sensor_stall stays high while a word is being worked on. The hand-off cycle
// repeats for as long as the previous word still waits in the output register
// under speed_stall. A finished word waits in the output register while the
// next sensor word is already accepted. The gains and base speed are written
// over the cfg port, which is always ready, and should only be changed while no
// word is in progress.
`include "line_follower_pid_drive_defines.svh"

module line_follower_pid_drive
    import lfpid_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [GAIN_W-1:0]    cfg_data,
    input  logic                 sensor_valid,
    output logic                 sensor_stall,
    input  logic [4:0]           sensor_levels,
    output logic                 speed_valid,
    input  logic                 speed_stall,
    output logic [SPEED_W-1:0]   left_speed,
    output logic [SPEED_W-1:0]   right_speed
);

    lfpid_state_t state_reg, state_next;

    logic [GAIN_W-1:0]  gain_prop_reg, gain_integ_reg, gain_deriv_reg;
    logic [SPEED_W-1:0] base_speed_reg;

    logic signed [ERR_W-1:0]   last_error_reg, last_error_next;
    logic signed [INTEG_W-1:0] integral_reg, integral_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [DER_W-1:0]   deriv_reg, deriv_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [SPEED_W-1:0]        left_tmp_reg, left_tmp_next;
    logic [SPEED_W-1:0]        right_tmp_reg, right_tmp_next;
    logic                      speed_valid_reg, speed_valid_next;
    logic [SPEED_W-1:0]        left_speed_reg, left_speed_next;
    logic [SPEED_W-1:0]        right_speed_reg, right_speed_next;

    logic                      sensor_accept;
    logic                      out_free;
    logic [4:0]                active;
    logic signed [ERR_W-1:0]   err_now;
    logic signed [INTEG_W:0]   integ_wide;
    logic [GAIN_W-1:0]         mul_gain;
    logic signed [OPND_W-1:0]  mul_opnd;
    logic signed [PROD_W-1:0]  mul_out;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [SUM_W-1:0]   base_q16;
    logic signed [SUM_W-1:0]   acc_side;
    logic signed [SUM_W-1:0]   spd_sum;

    assign cfg_ready     = 1'b1;
    assign sensor_stall  = (state_reg != ST_IDLE);
    assign sensor_accept = sensor_valid && !sensor_stall;
    assign out_free      = !speed_valid_reg || !speed_stall;
    assign speed_valid   = speed_valid_reg;
    assign left_speed    = left_speed_reg;
    assign right_speed   = right_speed_reg;

    assign active     = ~sensor_levels;
    assign err_now    = (active == 5'd0) ? last_error_reg : err_of(active);
    assign integ_wide = $signed({integral_reg[INTEG_W-1], integral_reg})
                      + $signed({{(INTEG_W - ERR_W + 1){err_now[ERR_W-1]}}, err_now});

    always_comb
    begin
        case (state_reg)
            ST_MUL_P:
            begin
                mul_gain = gain_prop_reg;
                mul_opnd = OPND_W'(err_reg);
            end
            ST_MUL_I:
            begin
                mul_gain = gain_integ_reg;
                mul_opnd = integral_reg;
            end
            default:
            begin
                mul_gain = gain_deriv_reg;
                mul_opnd = OPND_W'(deriv_reg);
            end
        endcase
    end

    assign mul_out  = $signed({1'b0, mul_gain}) * mul_opnd;
    assign prod_ext = ACC_W'(prod_reg);
    assign base_q16 = $signed({{(SUM_W - SPEED_W - 16){1'b0}}, base_speed_reg, 16'd0});
    assign acc_side = (state_reg == ST_LEFT) ? SUM_W'(acc_reg) : -SUM_W'(acc_reg);
    assign spd_sum  = base_q16 + acc_side;

    always_comb
    begin
        state_next       = state_reg;
        last_error_next  = last_error_reg;
        integral_next    = integral_reg;
        err_next         = err_reg;
        deriv_next       = deriv_reg;
        prod_next        = prod_reg;
        acc_next         = acc_reg;
        left_tmp_next    = left_tmp_reg;
        right_tmp_next   = right_tmp_reg;
        speed_valid_next = speed_valid_reg && speed_stall;
        left_speed_next  = left_speed_reg;
        right_speed_next = right_speed_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sensor_accept)
                begin
                    err_next        = err_now;
                    deriv_next      = DER_W'(err_now) - DER_W'(last_error_reg);
                    last_error_next = err_now;
                    if (integ_wide[INTEG_W] != integ_wide[INTEG_W-1])
                    begin
                        integral_next = integ_wide[INTEG_W] ? INTEG_MIN : INTEG_MAX;
                    end
                    else
                    begin
                        integral_next = integ_wide[INTEG_W-1:0];
                    end
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P:
            begin
                prod_next  = mul_out;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                acc_next   = prod_ext;
                prod_next  = mul_out;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                acc_next   = acc_reg + prod_ext;
                prod_next  = mul_out;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next   = acc_reg + prod_ext;
                state_next = ST_LEFT;
            end
            ST_LEFT:
            begin
                left_tmp_next = speed_of(spd_sum);
                state_next    = ST_RIGHT;
            end
            ST_RIGHT:
            begin
                right_tmp_next = speed_of(spd_sum);
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    speed_valid_next = 1'b1;
                    left_speed_next  = left_tmp_reg;
                    right_speed_next = right_tmp_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            speed_valid_reg <= 1'b0;
            last_error_reg  <= '0;
            integral_reg    <= '0;
            gain_prop_reg   <= GAIN_PROP_RST;
            gain_integ_reg  <= GAIN_INTEG_RST;
            gain_deriv_reg  <= GAIN_DERIV_RST;
            base_speed_reg  <= BASE_SPEED_RST;
        end
        else
        begin
            state_reg       <= state_next;
            speed_valid_reg <= speed_valid_next;
            last_error_reg  <= last_error_next;
            integral_reg    <= integral_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAIN_PROP:  gain_prop_reg  <= cfg_data;
                    REG_GAIN_INTEG: gain_integ_reg <= cfg_data;
                    REG_GAIN_DERIV: gain_deriv_reg <= cfg_data;
                    REG_BASE_SPEED: base_speed_reg <= cfg_data[SPEED_W-1:0];
                    default:        base_speed_reg <= base_speed_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg         <= err_next;
        deriv_reg       <= deriv_next;
        prod_reg        <= prod_next;
        acc_reg         <= acc_next;
        left_tmp_reg    <= left_tmp_next;
        right_tmp_reg   <= right_tmp_next;
        left_speed_reg  <= left_speed_next;
        right_speed_reg <= right_speed_next;
    end

    `LFPID_ASSERT_NEXT(a_accept_starts, sensor_accept, state_reg == ST_MUL_P,
        "accepted word did not start the multiply sequence")
    `LFPID_ASSERT_NEXT(a_emit_shows, (state_reg == ST_EMIT) && out_free,
        speed_valid && (state_reg == ST_IDLE), "finished word was not presented")
    `LFPID_ASSERT_NEXT(a_hold_error, sensor_accept && (sensor_levels == 5'b11111),
        last_error_reg == $past(last_error_reg), "error not held with no sensor on the line")

endmodule
